// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Field widths, status codes, controller states and the command and flag
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  // default table depth and fixed field widths
  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 5;
  localparam int RECORD_W  = KEY_W + PAYLOAD_W;

  // operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_TEST,
    S_INS_CHK,
    S_DEL_TEST,
    S_DEL_CHK,
    S_SHF_TEST,
    S_SHF_WR
  } state_t;

  // read address source, relative to the working index
  typedef enum logic [1:0] {
    RD_PREV,
    RD_CUR,
    RD_NEXT
  } rd_sel_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    load;
    logic    idx_from_count;
    logic    idx_clear;
    logic    idx_dec;
    logic    idx_inc;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_new;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    done;
    status_t status;
  } cmd_t;

  // status flags from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_at_count;
    logic idx_next_at_count;
    logic key_lt;
    logic key_eq;
  } flags_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_key_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_core: sorted table of key and payload records
// Keeps up to DEPTH records in ascending key order with insert and delete
// by key; every operation returns a status and the new record count.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Its single result
// appears for exactly one cycle with done high, in the cycle after the last
// working step, and the receiver cannot hold it off. Records sit in a memory
// with one read port, so every record visited takes a read state and then a
// check or write state: an insert visits each record it moves up and then
// the record that stops it, if any, a delete that finds its key visits every
// record of the table, wherever the key sits, and a full or empty refusal
// returns in the next cycle. A new operation may be taken in the cycle its
// predecessor's result is shown.
`default_nettype none

module sorted_key_table_core #(
  parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          opcode,
  input  wire logic [skt_pkg::KEY_W-1:0]     key,
  input  wire logic [skt_pkg::PAYLOAD_W-1:0] payload,
  output logic                               done,
  output logic [skt_pkg::STATUS_W-1:0]       status,
  output logic [skt_pkg::COUNT_W-1:0]        record_count
);

  skt_pkg::cmd_t   cmd;
  skt_pkg::flags_t flags;

  // operation sequencer
  skt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .flags  (flags),
    .cmd    (cmd),
    .busy   (busy)
  );

  // record storage and compare
  skt_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .key          (key),
    .payload      (payload),
    .flags        (flags),
    .done         (done),
    .status       (status),
    .record_count (record_count)
  );

endmodule

`default_nettype wire

// ----- rtl/skt_ram.sv -----
// ----------------------------------------------------------------------------
// skt_ram: generic single write port, single read port memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/skt_dpath.sv -----
// ----------------------------------------------------------------------------
// skt_dpath: datapath of the sorted key table
// Holds the operand registers, working index, record count, the record
// memory and the result register; raises flags for the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_dpath #(
  parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire skt_pkg::cmd_t                 cmd,
  input  wire logic [skt_pkg::KEY_W-1:0]     key,
  input  wire logic [skt_pkg::PAYLOAD_W-1:0] payload,
  output skt_pkg::flags_t                    flags,
  output logic                               done,
  output logic [skt_pkg::STATUS_W-1:0]       status,
  output logic [skt_pkg::COUNT_W-1:0]        record_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [skt_pkg::KEY_W-1:0]     op_key;
  logic [skt_pkg::PAYLOAD_W-1:0] op_payload;
  logic [CW-1:0]                 idx;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 idx_prev;
  logic [CW-1:0]                 idx_succ;
  logic [CW-1:0]                 rd_idx;
  logic [skt_pkg::RECORD_W-1:0]  rd_data;
  logic [skt_pkg::RECORD_W-1:0]  wr_data;
  logic [skt_pkg::KEY_W-1:0]     rd_key;
  logic [CW+skt_pkg::COUNT_W-1:0] count_ext;

  assign idx_prev = idx - CW'(1);
  assign idx_succ = idx + CW'(1);
  assign rd_key   = rd_data[skt_pkg::RECORD_W-1:skt_pkg::PAYLOAD_W];

  // operand capture on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_key     <= key;
      op_payload <= payload;
    end
  end

  // working index
  always_ff @(posedge clk) begin
    if (cmd.idx_from_count) begin
      idx <= count;
    end else if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_dec) begin
      idx <= idx_prev;
    end else if (cmd.idx_inc) begin
      idx <= idx_succ;
    end
  end

  // record count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= idx_succ - idx + count;
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      skt_pkg::RD_PREV: rd_idx = idx_prev;
      skt_pkg::RD_CUR:  rd_idx = idx;
      skt_pkg::RD_NEXT: rd_idx = idx_succ;
      default:          rd_idx = idx;
    endcase
  end

  assign wr_data = cmd.wr_new ? {op_key, op_payload} : rd_data;

  // record memory, key in the upper half
  skt_ram #(
    .WIDTH (skt_pkg::RECORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (idx[AW-1:0]),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_data)
  );

  // flags for the controller
  always_comb begin
    flags.full              = (count == CW'(DEPTH));
    flags.empty             = (count == '0);
    flags.idx_zero          = (idx == '0);
    flags.idx_at_count      = (idx == count);
    flags.idx_next_at_count = (idx_succ == count);
    flags.key_lt            = (rd_key < op_key);
    flags.key_eq            = (rd_key == op_key);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      status <= cmd.status;
    end
  end

  // count masked to the result field
  assign count_ext    = {{skt_pkg::COUNT_W{1'b0}}, count};
  assign record_count = count_ext[skt_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl: controller of the sorted key table
// Sequences the search and the record moves of insert and delete through
// the single read port of the record memory.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            opcode,
  input  wire skt_pkg::flags_t flags,
  output skt_pkg::cmd_t        cmd,
  output logic                 busy
);

  skt_pkg::state_t state;
  skt_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != skt_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = skt_pkg::RD_CUR;
    cmd.status = skt_pkg::ST_INSERTED;
    unique case (state)
      skt_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (opcode == skt_pkg::OP_INSERT) begin
            if (flags.full) begin
              cmd.done   = 1'b1;
              cmd.status = skt_pkg::ST_FULL;
            end else begin
              cmd.idx_from_count = 1'b1;
              state_next         = skt_pkg::S_INS_TEST;
            end
          end else begin
            if (flags.empty) begin
              cmd.done   = 1'b1;
              cmd.status = skt_pkg::ST_EMPTY;
            end else begin
              cmd.idx_clear = 1'b1;
              state_next    = skt_pkg::S_DEL_TEST;
            end
          end
        end
      end
      // insert: walk down from the top, moving keys not below the new key up one slot
      skt_pkg::S_INS_TEST: begin
        if (flags.idx_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.done    = 1'b1;
          state_next  = skt_pkg::S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = skt_pkg::RD_PREV;
          state_next = skt_pkg::S_INS_CHK;
        end
      end
      skt_pkg::S_INS_CHK: begin
        cmd.wr_en = 1'b1;
        if (!flags.key_lt) begin
          cmd.idx_dec = 1'b1;
          state_next  = skt_pkg::S_INS_TEST;
        end else begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.done    = 1'b1;
          state_next  = skt_pkg::S_IDLE;
        end
      end
      // delete: search upward for the first matching key
      skt_pkg::S_DEL_TEST: begin
        if (flags.idx_at_count) begin
          cmd.done   = 1'b1;
          cmd.status = skt_pkg::ST_NOTFOUND;
          state_next = skt_pkg::S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = skt_pkg::S_DEL_CHK;
        end
      end
      skt_pkg::S_DEL_CHK: begin
        if (flags.key_lt) begin
          cmd.idx_inc = 1'b1;
          state_next  = skt_pkg::S_DEL_TEST;
        end else if (flags.key_eq) begin
          state_next = skt_pkg::S_SHF_TEST;
        end else begin
          cmd.done   = 1'b1;
          cmd.status = skt_pkg::ST_NOTFOUND;
          state_next = skt_pkg::S_IDLE;
        end
      end
      // close the gap, moving later records down one slot
      skt_pkg::S_SHF_TEST: begin
        if (flags.idx_next_at_count) begin
          cmd.cnt_dec = 1'b1;
          cmd.done    = 1'b1;
          cmd.status  = skt_pkg::ST_DELETED;
          state_next  = skt_pkg::S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = skt_pkg::RD_NEXT;
          state_next = skt_pkg::S_SHF_WR;
        end
      end
      skt_pkg::S_SHF_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = skt_pkg::S_SHF_TEST;
      end
      default: begin
        state_next = skt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted key table
// Drives insert and delete commands through the start/busy handshake and
// keeps its own sorted copy of the table. Every done strobe is checked
// against the oldest outstanding status and record count.
// ----------------------------------------------------------------------------

import skt_pkg::*;

typedef struct {
  status_t        st;
  logic [COUNT_W-1:0] cnt;
} table_result_t;

// sorted table copy plus the queue of outstanding results
class table_scoreboard;
  logic [KEY_W-1:0]     keys [DEPTH_DEF];
  logic [PAYLOAD_W-1:0] payloads [DEPTH_DEF];
  int unsigned          count;
  table_result_t        outstanding_q [$];
  int unsigned          fails;

  function new();
    count = 0;
    fails = 0;
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fails++;
  endtask

  function int unsigned pending();
    return outstanding_q.size();
  endfunction

  // first position holding a key not below k
  function int unsigned first_not_below(logic [KEY_W-1:0] k);
    int unsigned pos;
    pos = 0;
    while (pos < count && keys[pos] < k) pos++;
    return pos;
  endfunction

  // apply one accepted transfer and queue the result it must produce
  function void note_input(op_t op, logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p);
    table_result_t r;
    int unsigned   pos;
    if (op == OP_INSERT) begin
      if (count >= DEPTH_DEF) begin
        r.st = ST_FULL;
      end else begin
        pos = first_not_below(k);
        for (int unsigned i = count; i > pos; i--) begin
          keys[i]     = keys[i-1];
          payloads[i] = payloads[i-1];
        end
        keys[pos]     = k;
        payloads[pos] = p;
        count++;
        r.st = ST_INSERTED;
      end
    end else begin
      if (count == 0) begin
        r.st = ST_EMPTY;
      end else begin
        pos = first_not_below(k);
        if (pos < count && keys[pos] == k) begin
          for (int unsigned i = pos; i + 1 < count; i++) begin
            keys[i]     = keys[i+1];
            payloads[i] = payloads[i+1];
          end
          count--;
          r.st = ST_DELETED;
        end else begin
          r.st = ST_NOTFOUND;
        end
      end
    end
    r.cnt = count[COUNT_W-1:0];
    outstanding_q.push_back(r);
  endfunction

  // compare one strobed result with the oldest outstanding one
  task check_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt);
    table_result_t e;
    if (outstanding_q.size() == 0) begin
      report($sformatf("result with nothing outstanding: status %0d count %0d", st, cnt));
    end else begin
      e = outstanding_q.pop_front();
      if (st !== e.st)
        report($sformatf("status %0d, wanted %0d", st, e.st));
      if (cnt !== e.cnt)
        report($sformatf("record_count %0d, wanted %0d", cnt, e.cnt));
    end
  endtask
endclass

module tb_top;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 285;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 opcode = OP_INSERT;
  logic [KEY_W-1:0]     key = '0;
  logic [PAYLOAD_W-1:0] payload = '0;
  logic                 busy;
  logic                 done;
  logic [STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]   record_count;

  table_scoreboard      sb = new();
  int unsigned          idle_pct;
  logic [KEY_W-1:0]     key_pool [8];
  bit                   filling;

  sorted_key_table_core #(.DEPTH(DEPTH_DEF)) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .key          (key),
    .payload      (payload),
    .done         (done),
    .status       (status),
    .record_count (record_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one command transfer, then an optional idle gap
  task automatic send_cmd(op_t op, logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p);
    int unsigned gap;
    start   <= 1'b1;
    opcode  <= op;
    key     <= k;
    payload <= p;
    do @(posedge clk); while (busy);
    sb.note_input(op, k, p);
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every outstanding result has been strobed
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
  endtask

  // keys mostly from a small pool or the stored set so deletes hit
  function automatic logic [KEY_W-1:0] pick_key(op_t op);
    int unsigned sel;
    sel = $urandom_range(99);
    if (op == OP_DELETE && sb.count != 0 && sel < 60)
      return sb.keys[$urandom_range(sb.count - 1)];
    if (sel < 75)
      return key_pool[$urandom_range(7)];
    if (sel < 85)
      return key_pool[$urandom_range(7)] + 1;
    return $urandom();
  endfunction

  task automatic random_phase(int unsigned pct);
    op_t         op;
    int unsigned n;
    idle_pct = pct;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if (n % 64 == 0) refresh_pool();
      // swing between full and empty so both refusals come up often
      if (sb.count >= DEPTH_DEF) filling = 1'b0;
      else if (sb.count == 0) filling = 1'b1;
      if (filling) op = ($urandom_range(99) < 75) ? OP_INSERT : OP_DELETE;
      else op = ($urandom_range(99) < 75) ? OP_DELETE : OP_INSERT;
      if ($urandom_range(99) < 4) op = op_t'(~op);
      send_cmd(op, pick_key(op), $urandom());
    end
  endtask

  // result strobes go straight to the scoreboard
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(status, record_count);
  end

  // give up when nothing moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || done || (start && !busy)) quiet = 0;
      else quiet++;
    end
    $display("[sorted_key_table_core] ERROR");
    $finish;
  end

  initial begin : stimulus
    idle_pct = 0;
    filling  = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty, extremes, duplicates, absent key, full table
    send_cmd(OP_DELETE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
    send_cmd(OP_INSERT, 32'h8000_0000, 32'h5A5A_5A5A);
    send_cmd(OP_DELETE, 32'h7FFF_FFFF, 32'h0000_0000);
    send_cmd(OP_DELETE, 32'h8000_0000, 32'h0000_0000);
    send_cmd(OP_DELETE, 32'h8000_0000, 32'h0000_0000);
    send_cmd(OP_DELETE, 32'h8000_0000, 32'h0000_0000);
    // descending keys land near the front, so each moves the whole tail
    for (int i = 14; i > 0; i--)
      send_cmd(OP_INSERT, 32'h1000 * i, ~(32'h1000 * i));
    send_cmd(OP_INSERT, 32'h0000_0001, 32'h1234_5678);
    send_cmd(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_drained();

    // random traffic under several sender idling rates
    random_phase(0);
    random_phase(47);
    wait_drained();
    random_phase(0);
    random_phase(25);

    // let the last results arrive, then a margin for anything stray
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.fails == 0) begin
      $display("[sorted_key_table_core] OK");
    end else begin
      $display("[sorted_key_table_core] ERROR");
    end
    $finish;
  end

endmodule
